[rtl/core/hmr_pkg.sv]
// ----------------------------------------------------------------------------
// hmr_pkg: shared types and codes for the HID message reassembler
// Command queue entry, result item layout, result kinds and status codes.
// ----------------------------------------------------------------------------
package hmr_pkg;

    // One queue entry from the front to the back.
    typedef struct packed {
        logic is_tick;   // 1: timer tick, 0: end of a report
        logic good;      // report had exactly the right length
        logic bank;      // store bank that holds the report
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] chan_id;
        logic [7:0]  command;
        logic [15:0] msg_len;
        logic [7:0]  out_byte;
        logic [2:0]  status;
        logic        run_last;
    } t_result;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_BAD_LEN  = 3'd1;
    localparam logic [2:0] STATUS_INIT_EXP = 3'd2;
    localparam logic [2:0] STATUS_BAD_SEQ  = 3'd3;
    localparam logic [2:0] STATUS_TIMEOUT  = 3'd4;

    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

endpackage

[rtl/core/hmr_ram.sv]
// ----------------------------------------------------------------------------
// hmr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module hmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/hmr_front.sv]
// ----------------------------------------------------------------------------
// hmr_front: input side of the reassembler
// Writes report bytes into a ping-pong store, checks report length and
// queues one command per report end or timer tick.
// ----------------------------------------------------------------------------
module hmr_front #(
    parameter int REPORT_BYTES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_req_type,
    input  logic [7:0]                        i_in_byte,
    input  logic                              i_report_end,
    input  logic                              i_q_full,
    output logic                              o_push,
    output hmr_pkg::t_cmd                     o_cmd,
    input  logic                              i_rep_done,
    output logic                              o_we,
    output logic [$clog2(REPORT_BYTES):0]     o_waddr,
    output logic [7:0]                        o_wdata
);

    localparam int IW   = $clog2(REPORT_BYTES);
    localparam int CNTW = $clog2(REPORT_BYTES + 1);

    logic [CNTW-1:0] r_count;
    logic            r_bad;
    logic            r_bank;
    logic [1:0]      r_rep_out;   // reports queued or in work, one per bank

    logic w_accept;
    logic w_byte;
    logic w_room;
    logic w_rep_push;

    assign o_stall    = i_q_full || (r_rep_out == 2'd2);
    assign w_accept   = i_valid && !o_stall;
    assign w_byte     = w_accept && !i_req_type;
    assign w_room     = r_count < CNTW'(REPORT_BYTES);
    assign w_rep_push = w_byte && i_report_end;

    assign o_we    = w_byte && w_room;
    assign o_waddr = {r_bank, r_count[IW-1:0]};
    assign o_wdata = i_in_byte;

    assign o_push       = w_rep_push || (w_accept && i_req_type);
    assign o_cmd.is_tick = i_req_type;
    assign o_cmd.good    = !r_bad && (r_count == CNTW'(REPORT_BYTES - 1));
    assign o_cmd.bank    = r_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_bad     <= 1'b0;
            r_bank    <= 1'b0;
            r_rep_out <= 2'd0;
        end else begin
            if (w_byte) begin
                if (i_report_end) begin
                    r_count <= '0;
                    r_bad   <= 1'b0;
                    r_bank  <= !r_bank;
                end else if (w_room) begin
                    r_count <= r_count + CNTW'(1);
                end else begin
                    r_bad <= 1'b1;
                end
            end
            r_rep_out <= r_rep_out + {1'b0, w_rep_push} - {1'b0, i_rep_done};
        end
    end

endmodule

[rtl/core/hmr_cmd_queue.sv]
// ----------------------------------------------------------------------------
// hmr_cmd_queue: two-entry command FIFO between front and back
// Push only when not full, pop only when an entry is available.
// ----------------------------------------------------------------------------
module hmr_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hmr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output hmr_pkg::t_cmd o_cmd,
    output logic          o_avail,
    output logic          o_full
);

    hmr_pkg::t_cmd r_q [2];
    logic [1:0]    r_cnt;
    logic          r_wp;
    logic          r_rp;

    assign o_cmd   = r_q[r_rp];
    assign o_avail = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

[rtl/core/hmr_back.sv]
// ----------------------------------------------------------------------------
// hmr_back: message sequencer of the reassembler
// Pops commands, reads report header and payload from the store, keeps the
// message state and drives the registered result item.
// ----------------------------------------------------------------------------
module hmr_back #(
    parameter int REPORT_BYTES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [15:0]                   i_timeout,
    input  logic                          i_q_avail,
    input  hmr_pkg::t_cmd                 i_cmd,
    output logic                          o_pop,
    output logic                          o_rep_done,
    output logic                          o_ram_re,
    output logic [$clog2(REPORT_BYTES):0] o_ram_raddr,
    input  logic [7:0]                    i_ram_rdata,
    output logic                          o_valid,
    input  logic                          i_stall,
    output hmr_pkg::t_result              o_res
);

    localparam int IW          = $clog2(REPORT_BYTES);
    localparam int HDR_INIT    = 7;
    localparam int HDR_CONT    = 5;
    localparam int ROOM_INIT   = REPORT_BYTES - HDR_INIT;
    localparam int ROOM_CONT   = REPORT_BYTES - HDR_CONT;
    localparam int CW          = $clog2(ROOM_CONT + 1);
    localparam logic [2:0] HDR_LAST = 3'(HDR_INIT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_DECIDE,
        S_PAY_RD,
        S_PAY_WR,
        S_STAT
    } t_state;

    t_state           r_state;
    logic             r_bank;
    logic [2:0]       r_idx;
    logic [31:0]      r_hdr_chan;
    logic [7:0]       r_hdr_tag;
    logic [15:0]      r_hdr_len;
    logic [IW-1:0]    r_addr;
    logic [CW-1:0]    r_cnt;
    logic             r_rem_zero;
    logic             r_done;
    logic             r_valid;
    hmr_pkg::t_result r_res;

    // message state
    logic        r_collecting;
    logic [31:0] r_held_chan;
    logic [15:0] r_remaining;
    logic [7:0]  r_exp_seq;
    logic [15:0] r_time_left;

    logic          w_ready;
    logic [15:0]   w_avail;
    logic [15:0]   w_room;
    logic [CW-1:0] w_take;
    logic [15:0]   w_rem_after;

    function automatic hmr_pkg::t_result make_res(
        input logic [1:0]  kind,
        input logic [31:0] chan,
        input logic [7:0]  cmd,
        input logic [15:0] len,
        input logic [7:0]  byt,
        input logic [2:0]  st,
        input logic        last
    );
        hmr_pkg::t_result res;
        res.kind     = kind;
        res.chan_id  = chan;
        res.command  = cmd;
        res.msg_len  = len;
        res.out_byte = byt;
        res.status   = st;
        res.run_last = last;
        return res;
    endfunction

    function automatic hmr_pkg::t_result status_res(input logic [2:0] st);
        return make_res(hmr_pkg::KIND_STATUS, 32'd0, 8'd0, 16'd0, 8'd0, st, 1'b1);
    endfunction

    assign w_ready     = !r_valid || !i_stall;
    assign w_avail     = r_collecting ? r_remaining : r_hdr_len;
    assign w_room      = r_collecting ? 16'(ROOM_CONT) : 16'(ROOM_INIT);
    assign w_take      = (w_avail < w_room) ? w_avail[CW-1:0] : w_room[CW-1:0];
    assign w_rem_after = w_avail - 16'(w_take);

    assign o_pop      = (r_state == S_IDLE) && i_q_avail && w_ready;
    assign o_rep_done = r_done;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_comb begin
        o_ram_re    = 1'b0;
        o_ram_raddr = {r_bank, r_addr};
        case (r_state)
            S_HDR: begin
                o_ram_re    = r_idx != HDR_LAST;
                o_ram_raddr = {r_bank, IW'(r_idx)};
            end
            S_PAY_RD: begin
                o_ram_re = 1'b1;
            end
            default: begin
                o_ram_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= 1'b0;
            r_done       <= 1'b0;
            r_collecting <= 1'b0;
            r_held_chan  <= 32'd0;
            r_remaining  <= 16'd0;
            r_exp_seq    <= 8'd0;
            r_time_left  <= 16'd0;
        end else begin
            r_done <= 1'b0;
            if (!i_stall) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_cmd.is_tick) begin
                            if (r_collecting) begin
                                if (r_time_left <= 16'd1) begin
                                    r_time_left  <= 16'd0;
                                    r_collecting <= 1'b0;
                                    r_valid      <= 1'b1;
                                    r_res <= status_res(hmr_pkg::STATUS_TIMEOUT);
                                end else begin
                                    r_time_left <= r_time_left - 16'd1;
                                end
                            end
                        end else if (!i_cmd.good) begin
                            r_done <= 1'b1;
                            if (!r_collecting) begin
                                r_valid <= 1'b1;
                                r_res   <= status_res(hmr_pkg::STATUS_BAD_LEN);
                            end
                        end else begin
                            r_bank  <= i_cmd.bank;
                            r_idx   <= 3'd0;
                            r_state <= S_HDR;
                        end
                    end
                end
                S_HDR: begin
                    // read data arrives in the cycle after its address
                    case (r_idx)
                        3'd1: r_hdr_chan[7:0]   <= i_ram_rdata;
                        3'd2: r_hdr_chan[15:8]  <= i_ram_rdata;
                        3'd3: r_hdr_chan[23:16] <= i_ram_rdata;
                        3'd4: r_hdr_chan[31:24] <= i_ram_rdata;
                        3'd5: r_hdr_tag         <= i_ram_rdata;
                        3'd6: r_hdr_len[15:8]   <= i_ram_rdata;
                        3'd7: r_hdr_len[7:0]    <= i_ram_rdata;
                        default: ;
                    endcase
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == HDR_LAST) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (w_ready) begin
                        if (!r_collecting) begin
                            if (!r_hdr_tag[7]) begin
                                r_valid <= 1'b1;
                                r_res   <= status_res(hmr_pkg::STATUS_INIT_EXP);
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_held_chan  <= r_hdr_chan;
                                r_remaining  <= w_rem_after;
                                r_collecting <= w_rem_after != 16'd0;
                                r_exp_seq    <= 8'd0;
                                r_time_left  <= i_timeout;
                                r_valid      <= 1'b1;
                                r_res <= make_res(hmr_pkg::KIND_HEADER, r_hdr_chan,
                                                  r_hdr_tag, r_hdr_len, 8'd0,
                                                  hmr_pkg::STATUS_OK, 1'b0);
                                r_cnt      <= w_take;
                                r_addr     <= IW'(HDR_INIT);
                                r_rem_zero <= w_rem_after == 16'd0;
                                r_state    <= (w_take == '0) ? S_STAT : S_PAY_RD;
                            end
                        end else if (r_hdr_chan != r_held_chan) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (r_hdr_tag[7] || (r_hdr_tag != r_exp_seq)) begin
                            r_collecting <= 1'b0;
                            r_valid      <= 1'b1;
                            r_res        <= status_res(hmr_pkg::STATUS_BAD_SEQ);
                            r_done       <= 1'b1;
                            r_state      <= S_IDLE;
                        end else begin
                            r_exp_seq    <= r_exp_seq + 8'd1;
                            r_remaining  <= w_rem_after;
                            r_collecting <= w_rem_after != 16'd0;
                            r_cnt        <= w_take;
                            r_addr       <= IW'(HDR_CONT);
                            r_rem_zero   <= w_rem_after == 16'd0;
                            r_state      <= S_PAY_RD;
                        end
                    end
                end
                S_PAY_RD: begin
                    r_addr  <= r_addr + IW'(1);
                    r_state <= S_PAY_WR;
                end
                S_PAY_WR: begin
                    if (w_ready) begin
                        r_valid <= 1'b1;
                        r_res <= make_res(hmr_pkg::KIND_PAYLOAD, 32'd0, 8'd0, 16'd0,
                                          i_ram_rdata, hmr_pkg::STATUS_OK,
                                          (r_cnt == CW'(1)) && !r_rem_zero);
                        r_cnt <= r_cnt - CW'(1);
                        if (r_cnt == CW'(1)) begin
                            if (r_rem_zero) begin
                                r_state <= S_STAT;
                            end else begin
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_state <= S_PAY_RD;
                        end
                    end
                end
                S_STAT: begin
                    if (w_ready) begin
                        r_valid <= 1'b1;
                        r_res   <= status_res(hmr_pkg::STATUS_OK);
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/hid_message_reassembler.sv]
// ----------------------------------------------------------------------------
// hid_message_reassembler: U2F HID style message reassembly
// Rebuilds framed messages from HID reports delivered one byte per item.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one item is a report byte or a timer
// tick. Report bytes are taken one per cycle, unless stalled, into a
// two-bank store; the last byte (i_report_end) queues it for the sequencer.
// Output channel (o_valid / i_stall): one item per result, from a register.
// A report or tick may yield a run: a header (init reports only), payload
// bytes, and a status when the message ends or fails; o_run_last marks
// the last item of a run. The sequencer handles a tick in its idle state.
// For a good report it reads the header bytes and decides, then reads and
// sends each payload byte in turn through the single RAM read port, and
// sends a status when the message ends; it pops no new command until the
// report is done.
// The input stalls while the command queue is full or both store banks
// hold reports not yet done; a stalled output holds its item and the
// sequencer waits, so bytes keep flowing until the store fills up.
// Reset (synchronous, active low) clears all message state, the queue and
// sets timeout_ticks to 3000; the store needs no clearing.
// ----------------------------------------------------------------------------
module hid_message_reassembler #(
    parameter int REPORT_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_in_byte,
    input  logic        i_report_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_out_kind,
    output logic [31:0] o_chan_id,
    output logic [7:0]  o_command,
    output logic [15:0] o_msg_len,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_status,
    output logic        o_run_last
);

    // two banks of one report each
    localparam int AW = $clog2(REPORT_BYTES) + 1;

    logic [15:0] r_timeout;

    logic             w_q_full;
    logic             w_q_avail;
    logic             w_push;
    logic             w_pop;
    hmr_pkg::t_cmd    w_push_cmd;
    hmr_pkg::t_cmd    w_head_cmd;
    logic             w_rep_done;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [7:0]       w_wdata;
    logic             w_re;
    logic [AW-1:0]    w_raddr;
    logic [7:0]       w_rdata;
    hmr_pkg::t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= hmr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    hmr_front #(
        .REPORT_BYTES(REPORT_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_in_byte    (i_in_byte),
        .i_report_end (i_report_end),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd),
        .i_rep_done   (w_rep_done),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata)
    );

    hmr_ram #(
        .WIDTH(8),
        .DEPTH(2 ** AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // tick and report-end commands stay in input order
    hmr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_avail (w_q_avail),
        .o_full  (w_q_full)
    );

    hmr_back #(
        .REPORT_BYTES(REPORT_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_timeout   (r_timeout),
        .i_q_avail   (w_q_avail),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_rep_done  (w_rep_done),
        .o_ram_re    (w_re),
        .o_ram_raddr (w_raddr),
        .i_ram_rdata (w_rdata),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (w_res)
    );

    assign o_out_kind = w_res.kind;
    assign o_chan_id  = w_res.chan_id;
    assign o_command  = w_res.command;
    assign o_msg_len  = w_res.msg_len;
    assign o_out_byte = w_res.out_byte;
    assign o_status   = w_res.status;
    assign o_run_last = w_res.run_last;

endmodule

[rtl/core/hmr_checker.sv]
// ----------------------------------------------------------------------------
// hmr_checker: port-level assertions for the reassembler
// Watches the result channel for framing rules of a result run.
// ----------------------------------------------------------------------------
module hmr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_out_kind,
    input logic [31:0] o_chan_id,
    input logic [7:0]  o_command,
    input logic [15:0] o_msg_len,
    input logic [7:0]  o_out_byte,
    input logic [2:0]  o_status,
    input logic        o_run_last
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_kind) && $stable(o_chan_id)
            && $stable(o_command) && $stable(o_msg_len) && $stable(o_out_byte)
            && $stable(o_status) && $stable(o_run_last))
        else $error("result changed while stalled");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind == hmr_pkg::KIND_STATUS) |-> o_run_last)
        else $error("status item not last in its run");

    a_header_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind == hmr_pkg::KIND_HEADER) |-> !o_run_last)
        else $error("header item ends a run");

    a_hdr_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind != hmr_pkg::KIND_HEADER)
            |-> (o_chan_id == 32'd0) && (o_command == 8'd0) && (o_msg_len == 16'd0))
        else $error("header fields set on a non-header item");

endmodule

bind hid_message_reassembler hmr_checker u_hmr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_kind (o_out_kind),
    .o_chan_id  (o_chan_id),
    .o_command  (o_command),
    .o_msg_len  (o_msg_len),
    .o_out_byte (o_out_byte),
    .o_status   (o_status),
    .o_run_last (o_run_last)
);

[verif/hid_message_reassembler_tb.sv]
// ----------------------------------------------------------------------------
// hid_message_reassembler_tb: self-checking bench for HID message reassembly
// Feeds reports one byte per item, with timer ticks mixed in, and predicts
// every header, payload byte and completion status in a model of the framing
// rules. A monitor compares each output item with the oldest prediction.
// Directed tests cover each framing error, timeouts and sequence limits, and
// random traffic then runs mixed messages under several timeout settings.
// ----------------------------------------------------------------------------
module hid_message_reassembler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_BYTES = 64;
    localparam int INIT_ROOM    = REPORT_BYTES - 7;   // payload bytes in an init report
    localparam int CONT_ROOM    = REPORT_BYTES - 5;   // payload bytes in a continuation
    localparam int CYCLE_LIMIT  = 800_000;
    localparam int HOLD_CYCLES  = 700;
    localparam int SETTLE       = 40;                 // cycles past the last result

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    logic        i_req_type;
    logic [7:0]  i_in_byte;
    logic        i_report_end;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_out_kind;
    logic [31:0] o_chan_id;
    logic [7:0]  o_command;
    logic [15:0] o_msg_len;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_status;
    logic        o_run_last;

    hid_message_reassembler #(
        .REPORT_BYTES(REPORT_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req_type  (i_req_type),
        .i_in_byte   (i_in_byte),
        .i_report_end(i_report_end),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_kind  (o_out_kind),
        .o_chan_id   (o_chan_id),
        .o_command   (o_command),
        .o_msg_len   (o_msg_len),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_run_last  (o_run_last)
    );

    // ------------------------------------------------------------------------
    // Reassembly model state. Mirrors the block: one report being collected
    // byte by byte, plus the message in progress.
    // ------------------------------------------------------------------------
    logic [7:0]  rpt_mem [REPORT_BYTES];
    int unsigned rpt_fill;      // bytes of the current report stored so far
    bit          rpt_over;      // report ran past REPORT_BYTES
    bit          in_msg;        // a message is being collected
    logic [31:0] msg_chan;
    logic [15:0] bytes_left;    // payload bytes still owed by the message
    logic [7:0]  next_seq;
    logic [15:0] ticks_left;
    logic [15:0] tmo_setting;   // mirror of timeout_ticks

    hmr_pkg::t_result report_results[$];   // results of the item being predicted
    hmr_pkg::t_result pending_results[$];  // predicted, not yet seen at the output

    // Stimulus controls
    logic [7:0]  frame_buf[$];
    logic [31:0] chan_pool[3];
    int          tick_permille;
    bit          tx_calm;
    bit          rx_calm;
    bit          rx_hold_req;
    int          rx_hold_left;

    // Bookkeeping
    int          cycle_count;
    int          n_reports;
    int          n_ticks;
    int          n_results;
    int          n_mismatch;
    int          status_seen[5];

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic hmr_pkg::t_result make_result(logic [1:0] kind, logic [31:0] chan,
                                                     logic [7:0] cmd, logic [15:0] len,
                                                     logic [7:0] pbyte, logic [2:0] st);
        hmr_pkg::t_result r;
        r.kind     = kind;
        r.chan_id  = chan;
        r.command  = cmd;
        r.msg_len  = len;
        r.out_byte = pbyte;
        r.status   = st;
        r.run_last = 1'b0;
        return r;
    endfunction

    function automatic void push_status(logic [2:0] st);
        report_results.push_back(make_result(hmr_pkg::KIND_STATUS, '0, '0, '0, '0, st));
    endfunction

    // Emit payload from the stored report; closes the message when it is done.
    function automatic void copy_payload(int start, int room);
        int take;
        take = (int'(bytes_left) < room) ? int'(bytes_left) : room;
        for (int i = 0; i < take; i++)
            report_results.push_back(make_result(hmr_pkg::KIND_PAYLOAD, '0, '0, '0,
                                                 rpt_mem[start + i], hmr_pkg::STATUS_OK));
        bytes_left = bytes_left - 16'(take);
        if (bytes_left == 16'd0) begin
            in_msg = 1'b0;
            push_status(hmr_pkg::STATUS_OK);
        end
    endfunction

    // Decide what a completed report does to the message in progress.
    function automatic void close_report(bit good);
        logic [31:0] chan;
        logic [7:0]  tag;
        if (!good) begin
            // bad length only reported when no message is open
            if (!in_msg)
                push_status(hmr_pkg::STATUS_BAD_LEN);
            return;
        end
        chan = {rpt_mem[3], rpt_mem[2], rpt_mem[1], rpt_mem[0]};
        tag  = rpt_mem[4];
        if (!in_msg) begin
            if (!tag[7]) begin
                push_status(hmr_pkg::STATUS_INIT_EXP);
                return;
            end
            msg_chan   = chan;
            bytes_left = {rpt_mem[5], rpt_mem[6]};
            report_results.push_back(make_result(hmr_pkg::KIND_HEADER, chan, tag,
                                                 bytes_left, '0, hmr_pkg::STATUS_OK));
            in_msg     = 1'b1;
            next_seq   = 8'd0;
            ticks_left = tmo_setting;
            copy_payload(7, INIT_ROOM);
            return;
        end
        // foreign channel is dropped silently, whatever its type
        if (chan != msg_chan)
            return;
        if (tag[7] || tag != next_seq) begin
            in_msg = 1'b0;
            push_status(hmr_pkg::STATUS_BAD_SEQ);
            return;
        end
        next_seq = next_seq + 8'd1;
        copy_payload(5, CONT_ROOM);
    endfunction

    // Predict the results of one accepted item and queue them.
    function automatic void reassemble_item(bit tick, logic [7:0] data, bit rpt_end);
        bit               good;
        hmr_pkg::t_result r;
        report_results.delete();
        if (tick) begin
            if (in_msg) begin
                if (ticks_left <= 16'd1) begin
                    ticks_left = 16'd0;
                    in_msg     = 1'b0;
                    push_status(hmr_pkg::STATUS_TIMEOUT);
                end else begin
                    ticks_left = ticks_left - 16'd1;
                end
            end
        end else begin
            if (rpt_fill < REPORT_BYTES) begin
                rpt_mem[rpt_fill] = data;
                rpt_fill++;
            end else begin
                rpt_over = 1'b1;
            end
            if (rpt_end) begin
                good     = !rpt_over && rpt_fill == REPORT_BYTES;
                rpt_fill = 0;
                rpt_over = 1'b0;
                close_report(good);
            end
        end
        foreach (report_results[i]) begin
            r          = report_results[i];
            r.run_last = (i == report_results.size() - 1);
            pending_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Output side: stall pattern. A hold request from a test freezes the
    // output for HOLD_CYCLES, counted here.
    // ------------------------------------------------------------------------
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_left = HOLD_CYCLES;
                rx_hold_req  = 1'b0;
            end
            if (rx_hold_left > 0) begin
                i_stall <= 1'b1;
                rx_hold_left--;
            end else if (rx_calm) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < 28);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: compare each accepted item with the oldest prediction.
    // Values read right after the edge are the ones the edge sampled.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        hmr_pkg::t_result want;
        bit               bad;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (o_out_kind == hmr_pkg::KIND_STATUS && o_status <= hmr_pkg::STATUS_TIMEOUT)
                status_seen[o_status]++;
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("%0t: unexpected item kind=%0d st=%0d byte=%h last=%0d",
                             $realtime, o_out_kind, o_status, o_out_byte, o_run_last);
            end else begin
                want = pending_results.pop_front();
                bad  = (o_out_kind != want.kind) || (o_chan_id != want.chan_id) ||
                       (o_command != want.command) || (o_msg_len != want.msg_len) ||
                       (o_out_byte != want.out_byte) || (o_status != want.status) ||
                       (o_run_last != want.run_last);
                if (bad) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("%0t: mismatch on result %0d", $realtime, n_results);
                        $display("  want kind=%0d chan=%h cmd=%h len=%0d byte=%h st=%0d last=%0d",
                                 want.kind, want.chan_id, want.command, want.msg_len,
                                 want.out_byte, want.status, want.run_last);
                        $display("  got  kind=%0d chan=%h cmd=%h len=%0d byte=%h st=%0d last=%0d",
                                 o_out_kind, o_chan_id, o_command, o_msg_len,
                                 o_out_byte, o_status, o_run_last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offer one item and hold it until the block takes it. Valid stays high
    // on return so back-to-back items need no second assignment in a step.
    task automatic send_item(bit tick, logic [7:0] data, bit rpt_end);
        while (!tx_calm && $urandom_range(0, 99) < 28) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= tick;
        i_in_byte    <= data;
        i_report_end <= rpt_end;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        reassemble_item(tick, data, rpt_end);
        if (tick)
            n_ticks++;
    endtask

    // Send nbytes of frame_buf as one report (random filler past its end),
    // with ticks sprinkled in at tick_permille.
    task automatic send_frame(int nbytes);
        logic [7:0] data;
        for (int i = 0; i < nbytes; i++) begin
            if (tick_permille > 0 && $urandom_range(0, 999) < tick_permille)
                send_item(1'b1, 8'($urandom), 1'($urandom));
            data = (i < frame_buf.size()) ? frame_buf[i] : 8'($urandom);
            send_item(1'b0, data, i == nbytes - 1);
        end
        n_reports++;
    endtask

    // fill < 0 gives random payload, otherwise every payload byte is fill
    function automatic void build_init(logic [31:0] chan, logic [7:0] cmd,
                                       logic [15:0] len, int fill);
        frame_buf.delete();
        for (int i = 0; i < 4; i++)
            frame_buf.push_back(chan[8*i +: 8]);
        frame_buf.push_back(cmd);
        frame_buf.push_back(len[15:8]);
        frame_buf.push_back(len[7:0]);
        while (frame_buf.size() < REPORT_BYTES)
            frame_buf.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    endfunction

    function automatic void build_cont(logic [31:0] chan, logic [7:0] seq, int fill);
        frame_buf.delete();
        for (int i = 0; i < 4; i++)
            frame_buf.push_back(chan[8*i +: 8]);
        frame_buf.push_back(seq);
        while (frame_buf.size() < REPORT_BYTES)
            frame_buf.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    endfunction

    // Drop valid, let every predicted result drain, then let the block settle
    // (ticks and ignored reports leave no result behind to wait on).
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_timeout(logic [15:0] ticks);
        wait_idle();
        i_cfg_wdata <= ticks;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        tmo_setting = ticks;
        i_cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Messages that fit in the init report, field extremes included.
    task automatic test_single_report();
        build_init(32'h0000_0000, 8'h80, 16'd0, 8'h00);       // zero length
        send_frame(REPORT_BYTES);
        build_init(32'hFFFF_FFFF, 8'hFF, 16'(INIT_ROOM), 8'hFF);
        send_frame(REPORT_BYTES);
        build_init(32'h1234_5678, 8'h83, 16'd5, -1);
        send_frame(REPORT_BYTES);
    endtask

    task automatic test_multi_report();
        build_init(32'h0102_0304, 8'h90, 16'(INIT_ROOM + CONT_ROOM + 1), -1);
        send_frame(REPORT_BYTES);
        build_cont(32'h0102_0304, 8'd0, -1);
        send_frame(REPORT_BYTES);
        build_cont(32'h0102_0304, 8'd1, -1);
        send_frame(REPORT_BYTES);
    endtask

    task automatic test_framing_errors();
        // bad lengths and a continuation with nothing open
        build_init(32'h0000_0042, 8'h81, 16'd3, -1);
        send_frame(10);
        send_frame(1);
        send_frame(REPORT_BYTES + 6);
        build_cont(32'h0000_0042, 8'd0, -1);
        send_frame(REPORT_BYTES);
        // open message: bad lengths and other channels are dropped
        build_init(32'h0000_0042, 8'h81, 16'd300, -1);
        send_frame(REPORT_BYTES);
        build_cont(32'h0000_0042, 8'd0, -1);
        send_frame(30);
        send_frame(REPORT_BYTES + 2);
        send_frame(REPORT_BYTES);
        build_cont(32'h0000_0043, 8'd1, -1);
        send_frame(REPORT_BYTES);
        build_init(32'h8000_0042, 8'h86, 16'd4, -1);
        send_frame(REPORT_BYTES);
        // init on the open channel aborts it
        build_init(32'h0000_0042, 8'h86, 16'd4, -1);
        send_frame(REPORT_BYTES);
        // out-of-order sequence
        build_init(32'h0000_0042, 8'h81, 16'd300, -1);
        send_frame(REPORT_BYTES);
        build_cont(32'h0000_0042, 8'd5, -1);
        send_frame(REPORT_BYTES);
        // sequence with the type bit set never matches
        build_init(32'h0000_0042, 8'h81, 16'd300, -1);
        send_frame(REPORT_BYTES);
        build_cont(32'h0000_0042, 8'h80, -1);
        send_frame(REPORT_BYTES);
    endtask

    // Longest announced length; run the sequence up to 127, then 128 fails.
    task automatic test_sequence_limit();
        build_init(32'h00C0_FFEE, 8'h83, 16'hFFFF, -1);
        send_frame(REPORT_BYTES);
        for (int s = 0; s <= 128; s++) begin
            build_cont(32'h00C0_FFEE, 8'(s), -1);
            send_frame(REPORT_BYTES);
        end
    endtask

    task automatic test_timeout();
        set_timeout(16'd3);
        send_item(1'b1, 8'hFF, 1'b1);                       // tick with nothing open
        build_init(32'h0000_00A5, 8'h81, 16'd500, -1);
        send_frame(REPORT_BYTES);
        repeat (3) send_item(1'b1, 8'h00, 1'b0);            // third tick expires
        build_cont(32'h0000_00A5, 8'd0, -1);
        send_frame(REPORT_BYTES);
        // zero behaves as one tick
        set_timeout(16'd0);
        build_init(32'h0000_00A5, 8'h81, 16'd500, -1);
        send_frame(REPORT_BYTES);
        send_item(1'b1, 8'h5A, 1'b0);
        set_timeout(16'd1);
        build_init(32'h0000_00A5, 8'h81, 16'd500, -1);
        send_frame(REPORT_BYTES);
        send_item(1'b1, 8'hA5, 1'b1);
        // max setting; dense ticks inside reports must not disturb byte counts
        set_timeout(16'hFFFF);
        tick_permille = 300;
        build_init(32'h0000_00A5, 8'h81, 16'd100, -1);
        send_frame(REPORT_BYTES);
        build_cont(32'h0000_00A5, 8'd0, -1);
        send_frame(REPORT_BYTES);
        tick_permille = 0;
        set_timeout(hmr_pkg::TIMEOUT_RESET);
    endtask

    // Freeze the output while the sender keeps going; the store fills and
    // the input stalls. The sender then waits for a full drain.
    task automatic test_backpressure();
        tx_calm     = 1'b1;
        rx_hold_req = 1'b1;
        for (int k = 0; k < 4; k++) begin
            build_init(32'h0000_0100 + k, 8'h90, 16'(INIT_ROOM), -1);
            send_frame(REPORT_BYTES);
        end
        tx_calm = 1'b0;
        wait_idle();
    endtask

    // Stray report: bad length, foreign channel, or random header bytes.
    task automatic send_stray(logic [31:0] chan);
        case ($urandom_range(0, 3))
            0: begin
                build_cont(chan, 8'($urandom_range(0, 3)), -1);
                send_frame($urandom_range(1, REPORT_BYTES - 1));
            end
            1: begin
                build_cont(chan, 8'($urandom_range(0, 3)), -1);
                send_frame($urandom_range(REPORT_BYTES + 1, REPORT_BYTES + 6));
            end
            2: begin
                build_cont(chan ^ (32'd1 << $urandom_range(0, 31)),
                           8'($urandom_range(0, 3)), -1);
                send_frame(REPORT_BYTES);
            end
            default: begin
                build_cont(chan, 8'($urandom), -1);
                send_frame(REPORT_BYTES);
            end
        endcase
    endtask

    // One message: mostly well formed, sometimes broken part way, sometimes
    // just a stray report.
    task automatic run_random_message();
        logic [31:0] chan;
        logic [15:0] len;
        int          roll;
        int          conts;
        int          fault_at;
        bit          broken;
        // close anything left open first; the init on that channel aborts it
        if (in_msg) begin
            build_init(msg_chan, 8'h80 | 8'($urandom_range(0, 127)), 16'd0, -1);
            send_frame(REPORT_BYTES);
        end
        chan = chan_pool[$urandom_range(0, 2)];
        roll = $urandom_range(0, 99);
        if (roll >= 80) begin
            send_stray(chan);
            return;
        end
        len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(181, 420))
                                          : 16'($urandom_range(0, 180));
        build_init(chan, 8'h80 | 8'($urandom_range(0, 127)), len, -1);
        send_frame(REPORT_BYTES);
        conts    = (len <= INIT_ROOM) ? 0 : (int'(len) - INIT_ROOM + CONT_ROOM - 1) / CONT_ROOM;
        fault_at = (roll >= 68 && conts > 0) ? $urandom_range(0, conts - 1) : -1;
        broken   = 1'b0;
        for (int s = 0; s < conts && !broken; s++) begin
            if ($urandom_range(0, 99) < 8)
                send_stray(chan);
            if (s == fault_at) begin
                broken = 1'b1;
                case ($urandom_range(0, 2))
                    0: begin
                        build_cont(chan, 8'(s + 1 + $urandom_range(0, 200)), -1);
                        send_frame(REPORT_BYTES);
                    end
                    1: begin
                        build_init(chan, 8'h80 | 8'($urandom), 16'($urandom), -1);
                        send_frame(REPORT_BYTES);
                    end
                    default: ;  // abandoned part way
                endcase
            end else begin
                build_cont(chan, 8'(s), -1);
                send_frame(REPORT_BYTES);
            end
        end
    endtask

    // Phases of random messages, each under its own timeout setting.
    task automatic test_random_traffic();
        int          first_report;
        int          phase;
        logic [15:0] tmo;
        first_report = n_reports;
        phase        = 0;
        foreach (chan_pool[i])
            chan_pool[i] = $urandom;
        while (n_reports - first_report < 130) begin
            case (phase % 5)
                0:       tmo = hmr_pkg::TIMEOUT_RESET;
                1:       tmo = 16'($urandom_range(4, 40));
                2:       tmo = 16'hFFFF;
                3:       tmo = 16'd1;
                default: tmo = 16'($urandom_range(41, 400));
            endcase
            set_timeout(tmo);
            // every fifth phase runs flat out on both sides
            tx_calm       = (phase % 5 == 2);
            rx_calm       = (phase % 5 == 2);
            tick_permille = (phase % 5 == 2) ? 0 : 20;
            repeat (5) run_random_message();
            phase++;
        end
        tx_calm       = 1'b0;
        rx_calm       = 1'b0;
        tick_permille = 0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= 16'd0;
        i_valid      <= 1'b0;
        i_req_type   <= 1'b0;
        i_in_byte    <= 8'd0;
        i_report_end <= 1'b0;

        rpt_fill      = 0;
        rpt_over      = 1'b0;
        in_msg        = 1'b0;
        msg_chan      = '0;
        bytes_left    = '0;
        next_seq      = '0;
        ticks_left    = '0;
        tmo_setting   = hmr_pkg::TIMEOUT_RESET;
        tick_permille = 0;
        tx_calm       = 1'b0;
        rx_calm       = 1'b0;
        rx_hold_req   = 1'b0;
        rx_hold_left  = 0;
        cycle_count   = 0;
        n_reports     = 0;
        n_ticks       = 0;
        n_results     = 0;
        n_mismatch    = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_report();
        test_multi_report();
        test_framing_errors();
        test_timeout();
        test_sequence_limit();
        test_backpressure();
        test_random_traffic();
        wait_idle();

        if (pending_results.size() != 0) begin
            $display("%0d predicted results never arrived", pending_results.size());
            n_mismatch++;
        end
        $display("Sent %0d reports and %0d ticks; checked %0d result items, %0d mismatches",
                 n_reports, n_ticks, n_results, n_mismatch);
        $display("Completions: ok %0d, bad length %0d, init expected %0d, bad seq %0d, timeout %0d",
                 status_seen[hmr_pkg::STATUS_OK], status_seen[hmr_pkg::STATUS_BAD_LEN],
                 status_seen[hmr_pkg::STATUS_INIT_EXP], status_seen[hmr_pkg::STATUS_BAD_SEQ],
                 status_seen[hmr_pkg::STATUS_TIMEOUT]);
        if (n_mismatch == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
